[rtl/core/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and codes for the key/value table
// Holds the request codes, the controller states and the command and
// status structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Width of the input and result fields on the stream ports.
  localparam int FIELD_BITS = 32;
  localparam int REQ_BITS   = 2;

  // Search count register.
  localparam int                CFG_BITS      = 7;
  localparam logic [CFG_BITS-1:0] ENTRIES_RESET = 7'd64;

  // Request codes.
  localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;  // write zero to the key slot under the counter
    logic load_req;  // capture a new request and restart the counter
    logic scan_rd;   // read the slot under the counter and advance
    logic commit;    // update the table and load the result register
  } kvt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // counter is on the last slot of the clearing pass
    logic scan_end;    // every searched slot has been read
    logic out_busy;    // result register holds a transaction not yet taken
  } kvt_sts_t;

endpackage

[rtl/core/key_value_table_lookup_insert_remove.sv]
// ----------------------------------------------------------------------------
// key_value_table_lookup_insert_remove: key/value table with linear search
// One request at a time; the result and the next ready come together,
// later while an older result waits. The scan reads one slot per cycle
// from the key memory port, up to the search count limited to TABLE_SLOTS.
// After reset a clearing pass empties the key memory first, writing zero
// to every key slot.
// ----------------------------------------------------------------------------
module key_value_table_lookup_insert_remove #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Requests.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // [31:0] key, [63:32] value
  input  logic [kvt_pkg::REQ_BITS-1:0]  in_tuser,   // [1:0] req_type
  // Results.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [31:0] result_value
  output logic [0:0]                    out_tuser,  // [0] success
  // Search count register.
  input  logic                          cfg_wr_en,
  input  logic [kvt_pkg::CFG_BITS-1:0]  cfg_wr_data
);
  import kvt_pkg::*;

  kvt_cmd_t              cmd;
  kvt_sts_t              sts;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic [VALUE_BITS-1:0] out_value;
  logic                  out_success;

  // Fields are taken in their low KEY_BITS and VALUE_BITS bits.
  assign req_key   = KEY_BITS'(in_tdata[FIELD_BITS-1:0]);
  assign req_value = VALUE_BITS'(in_tdata[2*FIELD_BITS-1:FIELD_BITS]);

  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kvt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (in_tuser),
    .req_key     (req_key),
    .req_value   (req_value),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_value   (out_value),
    .out_success (out_success)
  );

  // Result fields on the output stream.
  assign out_tdata    = FIELD_BITS'(out_value);
  assign out_tuser[0] = out_success;

endmodule

[rtl/core/kvt_ctrl.sv]
// ----------------------------------------------------------------------------
// kvt_ctrl: request sequencer for the key/value table
// Runs the clearing pass after reset, then takes one request at a time,
// steps the slot scan and commits the result once the output is free.
// ----------------------------------------------------------------------------
module kvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  kvt_pkg::kvt_sts_t sts,
  output kvt_pkg::kvt_cmd_t cmd
);
  import kvt_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan_rd = !sts.scan_end;
      end
      ST_DONE: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/core/kvt_dp.sv]
// ----------------------------------------------------------------------------
// kvt_dp: key/value table datapath
// Holds the key and value memories, the slot counter, the match and free
// slot trackers, the search count register and the result register.
// ----------------------------------------------------------------------------
module kvt_dp #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kvt_pkg::kvt_cmd_t             cmd,
  output kvt_pkg::kvt_sts_t             sts,
  input  logic                          cfg_wr_en,
  input  logic [kvt_pkg::CFG_BITS-1:0]  cfg_wr_data,
  input  logic [kvt_pkg::REQ_BITS-1:0]  req_type,
  input  logic [KEY_BITS-1:0]           req_key,
  input  logic [VALUE_BITS-1:0]         req_value,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [VALUE_BITS-1:0]         out_value,
  output logic                          out_success
);
  import kvt_pkg::*;

  localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

  // Memories.
  logic [KEY_BITS-1:0]   key_mem [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] val_mem [TABLE_SLOTS];

  logic [CFG_BITS-1:0]   cfg_entries_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [ADDR_W-1:0]     rd_addr;

  logic [REQ_BITS-1:0]   type_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  key_nz_r;

  logic                  rd_vld_r;
  logic [ADDR_W-1:0]     idx_d_r;
  logic [KEY_BITS-1:0]   key_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  logic                  hit_r;
  logic [ADDR_W-1:0]     hit_idx_r;
  logic [VALUE_BITS-1:0] hit_val_r;
  logic                  present_r;
  logic                  free_r;
  logic [ADDR_W-1:0]     free_idx_r;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_success_r;

  logic                  key_hit;
  logic                  key_free;
  logic                  remove_ok;
  logic                  insert_ok;
  logic                  key_we;
  logic [ADDR_W-1:0]     key_wa;
  logic [KEY_BITS-1:0]   key_wd;
  logic                  val_we;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_success;

  // Search count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= ENTRIES_RESET;
    end else if (cfg_wr_en) begin
      cfg_entries_r <= cfg_wr_data;
    end
  end

  // Slot counter, shared by the clearing pass and the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load_req) begin
      cnt_r <= '0;
    end else if (cmd.clear_wr || cmd.scan_rd) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign rd_addr = cnt_r[ADDR_W-1:0];

  // The scan stops at the search count or at the table size, whichever is lower.
  assign sts.clear_last = (cnt_r == CNT_W'(TABLE_SLOTS - 1));
  assign sts.scan_end   = (CMP_W'(cnt_r) >= CMP_W'(cfg_entries_r)) ||
                          (cnt_r == CNT_W'(TABLE_SLOTS));
  assign sts.out_busy   = out_valid_r && !out_tready;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      type_r   <= req_type;
      key_r    <= req_key;
      value_r  <= req_value;
      key_nz_r <= (req_key != '0);
    end
  end

  // Table updates: zero during the clearing pass, then remove or insert.
  assign remove_ok = (type_r == REQ_REMOVE) && hit_r;
  assign insert_ok = (type_r == REQ_INSERT) && key_nz_r && !present_r && free_r;

  always_comb begin
    key_we = 1'b0;
    key_wa = rd_addr;
    key_wd = '0;
    if (cmd.clear_wr) begin
      key_we = 1'b1;
    end else if (cmd.commit) begin
      if (remove_ok) begin
        key_we = 1'b1;
        key_wa = hit_idx_r;
      end else if (insert_ok) begin
        key_we = 1'b1;
        key_wa = free_idx_r;
        key_wd = key_r;
      end
    end
  end

  assign val_we = cmd.commit && insert_ok;

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_r <= key_mem[rd_addr];
  end

  // Value memory: read alongside the key so a match has its value at hand.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[free_idx_r] <= value_r;
    end
    val_rd_r <= val_mem[rd_addr];
  end

  // Slot index that goes with the read data.
  always_ff @(posedge clk) begin
    idx_d_r <= rd_addr;
  end

  // Compare of the slot read in the previous cycle.
  assign key_hit  = rd_vld_r && key_nz_r && (key_rd_r == key_r);
  assign key_free = rd_vld_r && (key_rd_r == '0);

  // Scan flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      hit_r     <= 1'b0;
      present_r <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.load_req) begin
        hit_r     <= 1'b0;
        present_r <= 1'b0;
        free_r    <= 1'b0;
      end else begin
        if (key_hit) begin
          hit_r     <= 1'b1;
          present_r <= 1'b1;
        end
        if (key_free) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  // The first match wins; the last empty slot seen is the highest one.
  always_ff @(posedge clk) begin
    if (key_hit && !hit_r) begin
      hit_idx_r <= idx_d_r;
      hit_val_r <= val_rd_r;
    end
    if (key_free) begin
      free_idx_r <= idx_d_r;
    end
  end

  // Result of the finished request.
  always_comb begin
    res_value   = '0;
    res_success = 1'b0;
    case (type_r) inside
      REQ_LOOKUP, REQ_REMOVE: begin
        res_value   = hit_r ? hit_val_r : '0;
        res_success = hit_r;
      end
      REQ_INSERT: begin
        res_success = insert_ok;
      end
      default: begin
        res_value   = '0;
        res_success = 1'b0;
      end
    endcase
  end

  // Result register; it frees when the transaction is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_value_r   <= res_value;
      out_success_r <= res_success;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_success = out_success_r;

  // A new result never overwrites one that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_tready))
    else $error("result committed over a pending transaction");

  // No slot is read beyond the searched range.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> !sts.scan_end)
    else $error("slot read past the search count");

  // A zero key never matches an empty slot.
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> key_nz_r)
    else $error("match recorded for a zero key");

  // The controller issues at most one command at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_wr, cmd.load_req, cmd.scan_rd, cmd.commit}))
    else $error("conflicting datapath commands");

endmodule
